/* sv/nfcs_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants of the NOR flash command sequencer.
// Depends on nothing; every other file imports it.
package nfcs_pkg;

   localparam int          JOB_DEPTH        = 4;
   localparam logic [31:0] FLASH_BASE_RESET = 32'h1000_0000;

   localparam logic [15:0] UNLOCK1_OFS = 16'h1554;
   localparam logic [15:0] UNLOCK2_OFS = 16'h0AA8;

   localparam logic [31:0] KEY1            = 32'hAAAA_AAAA;
   localparam logic [31:0] KEY2            = 32'h5555_5555;
   localparam logic [31:0] CMD_PROGRAM     = 32'hA0A0_A0A0;
   localparam logic [31:0] CMD_ERASE_SETUP = 32'h8080_8080;
   localparam logic [31:0] CMD_ERASE_CHIP  = 32'h1010_1010;
   localparam logic [31:0] CMD_RESET       = 32'hF0F0_F0F0;
   localparam logic [31:0] DQ7_MASK        = 32'h8080_8080;

   localparam logic [1:0] FUNC_RESET    = 2'd0;
   localparam logic [1:0] FUNC_PROGRAM  = 2'd1;
   localparam logic [1:0] FUNC_ERASE    = 2'd2;
   localparam logic [1:0] FUNC_RESPONSE = 2'd3;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   localparam int STEP_W = 3;

   typedef enum logic [2:0] {
      JOB_RESET,
      JOB_PROGRAM,
      JOB_ERASE,
      JOB_POLL,
      JOB_DONE
   } job_code_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] address;
      logic [31:0] word_data;
      logic        end_of_page;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] bus_addr;
      logic [31:0] bus_data;
      logic        last;
      logic        page_end;
   } rsp_type;

   typedef struct packed {
      job_code_type code;
      logic [15:0]  offset;
      logic [31:0]  data;
      logic         page_end;
   } job_type;

endpackage

/* sv/nfcs_front.sv */
`timescale 1ns / 1ps
// Front end: accepts request words, tracks the pending flash operation and
// turns each word it does not drop into a bus job. Depends on nfcs_pkg.
module nfcs_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  nfcs_pkg::req_type req_data,
   output logic             req_full,
   input  logic             job_full,
   output logic             job_push,
   output nfcs_pkg::job_type job
);
   import nfcs_pkg::*;

   typedef enum logic [1:0] {
      OP_IDLE,
      OP_PROGRAM,
      OP_ERASE,
      OP_RESET
   } op_type;

   op_type      op_ff, op_in;
   logic [15:0] poll_offset_ff, poll_offset_in;
   logic [31:0] expected_ff, expected_in;
   logic        page_end_ff, page_end_in;
   logic        accept;
   logic        job_valid;

   assign req_full = job_full;
   assign accept   = req_push && !job_full;
   assign job_push = accept && job_valid;

   always_comb begin
      op_in          = op_ff;
      poll_offset_in = poll_offset_ff;
      expected_in    = expected_ff;
      page_end_in    = page_end_ff;
      job_valid      = 1'b0;
      job.code       = JOB_DONE;
      job.offset     = '0;
      job.data       = '0;
      job.page_end   = 1'b0;
      case (req_data.func)
         FUNC_RESET: begin
            job_valid = 1'b1;
            job.code  = JOB_RESET;
            op_in     = OP_RESET;
         end
         FUNC_PROGRAM: begin
            if (op_ff == OP_IDLE) begin
               job_valid      = 1'b1;
               job.code       = JOB_PROGRAM;
               job.offset     = req_data.address;
               job.data       = req_data.word_data;
               op_in          = OP_PROGRAM;
               poll_offset_in = req_data.address;
               expected_in    = req_data.word_data;
               page_end_in    = req_data.end_of_page;
            end
         end
         FUNC_ERASE: begin
            if (op_ff == OP_IDLE) begin
               job_valid = 1'b1;
               job.code  = JOB_ERASE;
               op_in     = OP_ERASE;
            end
         end
         default: begin
            case (op_ff)
               OP_PROGRAM: begin
                  job_valid = 1'b1;
                  if ((req_data.word_data & DQ7_MASK) == (~expected_ff & DQ7_MASK)) begin
                     job.code   = JOB_POLL;
                     job.offset = poll_offset_ff;
                  end else begin
                     job.code     = JOB_DONE;
                     job.page_end = page_end_ff;
                     op_in        = OP_IDLE;
                  end
               end
               OP_ERASE: begin
                  job_valid = 1'b1;
                  if ((req_data.word_data & DQ7_MASK) != DQ7_MASK) begin
                     job.code = JOB_POLL;
                  end else begin
                     job.code = JOB_DONE;
                     op_in    = OP_IDLE;
                  end
               end
               OP_RESET: begin
                  job_valid = 1'b1;
                  job.code  = JOB_DONE;
                  op_in     = OP_IDLE;
               end
               default: begin
                  job_valid = 1'b0;
               end
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff          <= OP_IDLE;
         poll_offset_ff <= '0;
         expected_ff    <= '0;
         page_end_ff    <= 1'b0;
      end else if (accept) begin
         op_ff          <= op_in;
         poll_offset_ff <= poll_offset_in;
         expected_ff    <= expected_in;
         page_end_ff    <= page_end_in;
      end
   end

endmodule

/* sv/nfcs_job_fifo.sv */
`timescale 1ns / 1ps
// Short queue of bus jobs between the front end and the bus sequencer.
// Depends on nfcs_pkg.
module nfcs_job_fifo #(
   parameter int Depth = nfcs_pkg::JOB_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  nfcs_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output nfcs_pkg::job_type pop_job,
   output logic             empty
);
   import nfcs_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   job_type        mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full    = count_ff == CntW'(Depth);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* sv/nfcs_back.sv */
`timescale 1ns / 1ps
// Bus sequencer: expands each job into bus accesses, one word per cycle
// while the result register is empty or popped. Depends on nfcs_pkg.
module nfcs_back (
   input  logic             clock,
   input  logic             reset,
   input  logic [31:0]      flash_base,
   input  logic             job_valid,
   input  nfcs_pkg::job_type job,
   output logic             job_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output nfcs_pkg::rsp_type rsp_data
);
   import nfcs_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;
   logic              load;
   logic [1:0]        kind;
   logic [15:0]       offset;
   logic [31:0]       data;
   logic              last;

   assign load      = job_valid && (!out_valid_ff || rsp_pop);
   assign job_pop   = load && last;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      kind   = KIND_WRITE;
      offset = '0;
      data   = '0;
      last   = 1'b0;
      case (job.code)
         JOB_RESET: begin
            if (step_ff == STEP_W'(0)) begin
               data = CMD_RESET;
            end else begin
               kind = KIND_READ;
               last = 1'b1;
            end
         end
         JOB_PROGRAM: begin
            case (step_ff)
               STEP_W'(0): begin
                  offset = UNLOCK1_OFS;
                  data   = KEY1;
               end
               STEP_W'(1): begin
                  offset = UNLOCK2_OFS;
                  data   = KEY2;
               end
               STEP_W'(2): begin
                  offset = UNLOCK1_OFS;
                  data   = CMD_PROGRAM;
               end
               STEP_W'(3): begin
                  offset = job.offset;
                  data   = job.data;
               end
               default: begin
                  kind   = KIND_READ;
                  offset = job.offset;
                  last   = 1'b1;
               end
            endcase
         end
         JOB_ERASE: begin
            case (step_ff)
               STEP_W'(0), STEP_W'(3): begin
                  offset = UNLOCK1_OFS;
                  data   = KEY1;
               end
               STEP_W'(1), STEP_W'(4): begin
                  offset = UNLOCK2_OFS;
                  data   = KEY2;
               end
               STEP_W'(2): begin
                  offset = UNLOCK1_OFS;
                  data   = CMD_ERASE_SETUP;
               end
               STEP_W'(5): begin
                  offset = UNLOCK1_OFS;
                  data   = CMD_ERASE_CHIP;
               end
               default: begin
                  kind = KIND_READ;
                  last = 1'b1;
               end
            endcase
         end
         JOB_POLL: begin
            kind   = KIND_READ;
            offset = job.offset;
            last   = 1'b1;
         end
         default: begin
            kind = KIND_DONE;
            last = 1'b1;
         end
      endcase
   end

   always_comb begin
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         step_in         = last ? '0 : step_ff + 1'b1;
         out_valid_in    = 1'b1;
         out_in.kind     = kind;
         out_in.bus_addr = (kind == KIND_DONE) ? '0 : flash_base + {16'd0, offset};
         out_in.bus_data = data;
         out_in.last     = last;
         out_in.page_end = (kind == KIND_DONE) ? job.page_end : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

endmodule

/* sv/nor_flash_command_sequencer.sv */
`timescale 1ns / 1ps
// Top level of the NOR flash command sequencer: base address register,
// front end, job queue and bus sequencer. Depends on nfcs_pkg.
//
//   channel   ports                          moves
//   request   req_push, req_full, req_data   command or read response word
//   response  rsp_pop, rsp_empty, rsp_data   bus access or completion word
//   csr       csr_valid, csr_ready, csr_data flash base address
//
// The front end takes one request word per cycle while the job queue has room.
// The bus sequencer gives one response word per cycle while rsp_pop keeps pace: a reset
// gives two words, a program word five, a chip erase seven, a poll or completion one.
// Reset is synchronous and empties the queue and the response register.
// A stalled response side fills the queue, which then raises req_full.
module nor_flash_command_sequencer #(
   parameter int JobDepth = nfcs_pkg::JOB_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  nfcs_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output nfcs_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);
   import nfcs_pkg::*;

   logic [31:0] base_ff;
   logic        job_full;
   logic        job_push;
   job_type     front_job;
   logic        job_empty;
   logic        job_pop;
   job_type     queued_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= FLASH_BASE_RESET;
      end else if (csr_valid && csr_ready) begin
         base_ff <= csr_data;
      end
   end

   nfcs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .job_full (job_full),
      .job_push (job_push),
      .job      (front_job)
   );

   nfcs_job_fifo #(
      .Depth (JobDepth)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .full     (job_full),
      .pop      (job_pop),
      .pop_job  (queued_job),
      .empty    (job_empty)
   );

   nfcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .flash_base (base_ff),
      .job_valid  (!job_empty),
      .job        (queued_job),
      .job_pop    (job_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

/* test/tb_nor_flash_command_sequencer.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the NOR flash command sequencer. It sends command and
// read-response words, predicts every bus access and completion word, and checks them in order.
// Depends on nfcs_pkg and nor_flash_command_sequencer.
module tb_nor_flash_command_sequencer;
   import nfcs_pkg::*;

   localparam int RANDOM_ITEMS    = 180;
   localparam int PRESSURE_ITEMS  = 40;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT  = 3000;

   typedef enum logic [1:0] {
      OP_IDLE,
      OP_PROGRAMMING,
      OP_ERASING,
      OP_RESETTING
   } flash_op_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   logic    req_full;
   req_type req_data  = '0;
   logic    rsp_empty;
   logic    rsp_pop   = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [31:0] csr_data = '0;

   // Own copy of the sequencer's state, advanced on every accepted word.
   logic [31:0]  flash_base_copy  = FLASH_BASE_RESET;
   flash_op_type op_state         = OP_IDLE;
   logic [15:0]  polled_offset    = '0;
   logic [31:0]  programmed_word  = '0;
   logic         programmed_eop   = 1'b0;
   rsp_type      expected_accesses[$];

   int  mismatches      = 0;
   int  words_sent      = 0;
   int  results_checked = 0;
   int  base_writes     = 0;
   int  full_cycles     = 0;
   int  stall_cycles    = 0;
   int  burst_left      = 0;
   bit  steady_sender   = 1'b0;
   bit  hold_off_request = 1'b0;

   nor_flash_command_sequencer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type bus_word(logic [1:0] kind, logic [31:0] ofs, logic [31:0] data);
      rsp_type w;
      w.kind     = kind;
      w.bus_addr = flash_base_copy + ofs;
      w.bus_data = data;
      w.last     = 1'b0;
      w.page_end = 1'b0;
      return w;
   endfunction

   function automatic rsp_type done_word(logic page_end);
      rsp_type w;
      w          = '0;
      w.kind     = KIND_DONE;
      w.page_end = page_end;
      return w;
   endfunction

   task automatic predict_accesses(input req_type w);
      rsp_type words[$];
      case (w.func)
         FUNC_RESET: begin
            words.push_back(bus_word(KIND_WRITE, 32'h0, CMD_RESET));
            words.push_back(bus_word(KIND_READ, 32'h0, 32'h0));
            op_state = OP_RESETTING;
         end
         FUNC_PROGRAM: begin
            if (op_state == OP_IDLE) begin
               words.push_back(bus_word(KIND_WRITE, {16'h0, UNLOCK1_OFS}, KEY1));
               words.push_back(bus_word(KIND_WRITE, {16'h0, UNLOCK2_OFS}, KEY2));
               words.push_back(bus_word(KIND_WRITE, {16'h0, UNLOCK1_OFS}, CMD_PROGRAM));
               words.push_back(bus_word(KIND_WRITE, {16'h0, w.address}, w.word_data));
               words.push_back(bus_word(KIND_READ, {16'h0, w.address}, 32'h0));
               op_state        = OP_PROGRAMMING;
               polled_offset   = w.address;
               programmed_word = w.word_data;
               programmed_eop  = w.end_of_page;
            end
         end
         FUNC_ERASE: begin
            if (op_state == OP_IDLE) begin
               words.push_back(bus_word(KIND_WRITE, {16'h0, UNLOCK1_OFS}, KEY1));
               words.push_back(bus_word(KIND_WRITE, {16'h0, UNLOCK2_OFS}, KEY2));
               words.push_back(bus_word(KIND_WRITE, {16'h0, UNLOCK1_OFS}, CMD_ERASE_SETUP));
               words.push_back(bus_word(KIND_WRITE, {16'h0, UNLOCK1_OFS}, KEY1));
               words.push_back(bus_word(KIND_WRITE, {16'h0, UNLOCK2_OFS}, KEY2));
               words.push_back(bus_word(KIND_WRITE, {16'h0, UNLOCK1_OFS}, CMD_ERASE_CHIP));
               words.push_back(bus_word(KIND_READ, 32'h0, 32'h0));
               op_state = OP_ERASING;
            end
         end
         default: begin
            case (op_state)
               OP_PROGRAMMING: begin
                  if ((w.word_data & DQ7_MASK) == (~programmed_word & DQ7_MASK)) begin
                     words.push_back(bus_word(KIND_READ, {16'h0, polled_offset}, 32'h0));
                  end else begin
                     words.push_back(done_word(programmed_eop));
                     op_state = OP_IDLE;
                  end
               end
               OP_ERASING: begin
                  if ((w.word_data & DQ7_MASK) != DQ7_MASK) begin
                     words.push_back(bus_word(KIND_READ, 32'h0, 32'h0));
                  end else begin
                     words.push_back(done_word(1'b0));
                     op_state = OP_IDLE;
                  end
               end
               OP_RESETTING: begin
                  words.push_back(done_word(1'b0));
                  op_state = OP_IDLE;
               end
               default: ;
            endcase
         end
      endcase
      if (words.size() > 0) begin
         words[words.size() - 1].last = 1'b1;
      end
      foreach (words[i]) begin
         expected_accesses.push_back(words[i]);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_access(input rsp_type got);
      rsp_type want;
      if (expected_accesses.size() == 0) begin
         $error("result word with no expectation: kind %0d, bus_addr 0x%08h",
                got.kind, got.bus_addr);
         mismatches++;
      end else begin
         want = expected_accesses.pop_front();
         compare_field("kind", 32'(want.kind), 32'(got.kind));
         compare_field("bus_addr", want.bus_addr, got.bus_addr);
         compare_field("bus_data", want.bus_data, got.bus_data);
         compare_field("last", 32'(want.last), 32'(got.last));
         compare_field("page_end", 32'(want.page_end), 32'(got.page_end));
         results_checked++;
      end
   endtask

   always @(posedge clock) begin : monitor
      bit activity;
      activity = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            flash_base_copy = csr_data;
            base_writes++;
            activity = 1'b1;
         end
         if (req_push && !req_full) begin
            predict_accesses(req_data);
            words_sent++;
            activity = 1'b1;
         end
         if (req_push && req_full) begin
            full_cycles++;
         end
         if (rsp_pop && !rsp_empty) begin
            check_access(rsp_data);
            activity = 1'b1;
         end
      end
      stall_cycles = activity ? 0 : stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // The receiver switches between stall patterns; a long hold-off is counted here.
   initial begin : receiver
      int pattern;
      int pattern_left;
      pattern      = 0;
      pattern_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_request = 1'b0;
         end else begin
            if (pattern_left == 0) begin
               pattern      = $urandom_range(0, 3);
               pattern_left = $urandom_range(20, 80);
            end
            pattern_left--;
            case (pattern)
               0: rsp_pop <= 1'b1;
               1: rsp_pop <= 1'($urandom_range(0, 1));
               2: rsp_pop <= ($urandom_range(0, 3) == 0);
               default: rsp_pop <= (pattern_left % 3 == 0);
            endcase
         end
      end
   end

   function automatic req_type make_word(logic [1:0] func, logic [15:0] address,
                                         logic [31:0] data, logic eop);
      req_type w;
      w.func        = func;
      w.address     = address;
      w.word_data   = data;
      w.end_of_page = eop;
      return w;
   endfunction

   function automatic req_type random_word(logic [1:0] func);
      return make_word(func, 16'($urandom_range(0, 16'hFFFF)), $urandom(),
                       1'($urandom_range(0, 1)));
   endfunction

   // Read data for the operation in progress, chosen to keep it polling or to finish it.
   function automatic req_type poll_reply(bit keep_polling);
      req_type     w;
      logic [31:0] dq7;
      w = random_word(FUNC_RESPONSE);
      case (op_state)
         OP_PROGRAMMING: begin
            if (keep_polling) begin
               dq7 = ~programmed_word & DQ7_MASK;
            end else begin
               do dq7 = $urandom() & DQ7_MASK;
               while (dq7 == (~programmed_word & DQ7_MASK));
            end
         end
         OP_ERASING: begin
            if (keep_polling) begin
               do dq7 = $urandom() & DQ7_MASK;
               while (dq7 == DQ7_MASK);
            end else begin
               dq7 = DQ7_MASK;
            end
         end
         default: dq7 = w.word_data & DQ7_MASK;
      endcase
      w.word_data = (w.word_data & ~DQ7_MASK) | dq7;
      return w;
   endfunction

   function automatic bit is_ignored(req_type w);
      return ((w.func == FUNC_PROGRAM || w.func == FUNC_ERASE) && op_state != OP_IDLE)
             || (w.func == FUNC_RESPONSE && op_state == OP_IDLE);
   endfunction

   function automatic req_type random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (op_state == OP_IDLE) begin
         if (pick < 55) return random_word(FUNC_PROGRAM);
         if (pick < 75) return random_word(FUNC_ERASE);
         if (pick < 85) return random_word(FUNC_RESET);
         return random_word(FUNC_RESPONSE);
      end
      if (pick < 80) return poll_reply($urandom_range(0, 2) == 0);
      if (pick < 85) return random_word(FUNC_PROGRAM);
      if (pick < 90) return random_word(FUNC_ERASE);
      return random_word(FUNC_RESET);
   endfunction

   // Called and left at a falling edge; push stays high between words of one burst.
   task automatic send_word(input req_type w);
      if (!steady_sender) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            req_push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         burst_left--;
      end
      req_push <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_until_idle();
      req_push <= 1'b0;
      while (expected_accesses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_flash_base(input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic finish_operation();
      while (op_state != OP_IDLE) send_word(poll_reply(1'b0));
   endtask

   task automatic test_reset_command();
      send_word(make_word(FUNC_RESET, 16'h0000, 32'h0000_0000, 1'b0));
      send_word(make_word(FUNC_RESPONSE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
      // A response with nothing outstanding is dropped.
      send_word(make_word(FUNC_RESPONSE, 16'h5A5A, 32'h8080_8080, 1'b1));
   endtask

   task automatic test_program_word();
      send_word(make_word(FUNC_PROGRAM, 16'h0000, 32'h0000_0000, 1'b0));
      send_word(poll_reply(1'b1));
      send_word(poll_reply(1'b0));
      send_word(make_word(FUNC_PROGRAM, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
      // Commands arriving while a word is being programmed are dropped.
      send_word(make_word(FUNC_ERASE, 16'h1234, 32'h1234_5678, 1'b1));
      send_word(make_word(FUNC_PROGRAM, 16'hA5A5, 32'h7F7F_7F7F, 1'b0));
      send_word(poll_reply(1'b0));
   endtask

   task automatic test_chip_erase();
      send_word(make_word(FUNC_ERASE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
      send_word(make_word(FUNC_RESPONSE, 16'h0000, 32'h0000_0000, 1'b0));
      send_word(make_word(FUNC_RESPONSE, 16'h0000, 32'h8080_807F, 1'b0));
      send_word(make_word(FUNC_RESPONSE, 16'h0000, 32'h8080_8080, 1'b0));
   endtask

   task automatic test_reset_while_busy();
      send_word(make_word(FUNC_PROGRAM, 16'h0100, 32'hDEAD_BEEF, 1'b1));
      send_word(make_word(FUNC_RESET, 16'h0000, 32'h0000_0000, 1'b0));
      send_word(poll_reply(1'b0));
   endtask

   task automatic test_address_wrap();
      wait_until_idle();
      write_flash_base(32'hFFFF_FFF0);
      send_word(make_word(FUNC_PROGRAM, 16'hFFFF, 32'h0123_4567, 1'b1));
      send_word(poll_reply(1'b0));
      send_word(make_word(FUNC_ERASE, 16'h0000, 32'h0000_0000, 1'b0));
      send_word(poll_reply(1'b0));
      send_word(make_word(FUNC_RESET, 16'h0000, 32'h0000_0000, 1'b0));
      send_word(poll_reply(1'b0));
   endtask

   task automatic test_random_traffic();
      logic [31:0] bases[4];
      int          counted;
      req_type     w;
      bases = '{FLASH_BASE_RESET, 32'h0000_0000, 32'hFFFF_FFFF, $urandom()};
      foreach (bases[p]) begin
         wait_until_idle();
         write_flash_base(bases[p]);
         steady_sender = (p == 1);
         counted = 0;
         while (counted < RANDOM_ITEMS / 4) begin
            w = random_item();
            if (!is_ignored(w)) counted++;
            send_word(w);
         end
         finish_operation();
      end
      steady_sender = 1'b0;
   endtask

   // The receiver stops popping for a long stretch while words keep coming.
   task automatic test_back_pressure();
      int counted;
      req_type w;
      wait_until_idle();
      write_flash_base($urandom());
      steady_sender    = 1'b1;
      hold_off_request = 1'b1;
      counted = 0;
      while (counted < PRESSURE_ITEMS) begin
         w = random_item();
         if (!is_ignored(w)) counted++;
         send_word(w);
      end
      finish_operation();
      steady_sender = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_command();
      test_program_word();
      test_chip_erase();
      test_reset_while_busy();
      test_address_wrap();
      test_random_traffic();
      test_back_pressure();
      wait_until_idle();
      if (expected_accesses.size() != 0) begin
         $error("%0d expected result words never arrived", expected_accesses.size());
         mismatches += expected_accesses.size();
      end
      $display("Sent %0d request words, checked %0d result words, %0d base address writes.",
               words_sent, results_checked, base_writes);
      $display("Input held off by a full queue for %0d cycles.", full_cycles);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
